// ===== hw/rtl/bga_pkg.sv =====
// bga_pkg: shared types and constants of the battery gauge averaging block
// holds the controller state type, the command and status structs and the field widths
// no dependencies
package bga_pkg;

	localparam int CodeW   = 10;
	localparam int NumW    = 21;
	localparam int CountW  = 8;
	localparam int SumW    = 24;
	localparam int MvW     = 16;
	localparam int PctW    = 7;
	localparam int CfgIdxW = 1;
	localparam int CfgW    = 21;
	localparam int DivSteps = SumW;
	localparam int DivCntW  = $clog2(DivSteps + 1);

	localparam logic [CfgIdxW-1:0] CFG_SAMPLE_COUNT = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_REF_NUMER    = 1'b1;

	localparam logic [CountW-1:0] SampleCountReset = 8'd10;
	localparam logic [NumW-1:0]   RefNumerReset    = 21'd1125300;
	localparam logic [MvW-1:0]    MvSat            = 16'hFFFF;

	localparam logic [MvW-1:0] MvFull  = 16'd3000;
	localparam logic [MvW-1:0] MvEmpty = 16'd1800;
	localparam logic [MvW-1:0] MvKnee3 = 16'd2900;
	localparam logic [MvW-1:0] MvKnee2 = 16'd2700;
	localparam logic [MvW-1:0] MvKnee1 = 16'd2200;
	localparam logic [PctW-1:0] PctFull  = 7'd100;
	localparam logic [PctW-1:0] PctKnee3 = 7'd95;
	localparam logic [PctW-1:0] PctKnee2 = 7'd75;
	localparam logic [PctW-1:0] PctKnee1 = 7'd25;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_ACC,
		ST_CHECK,
		ST_AVG,
		ST_EMIT
	} st_t;

	typedef enum logic {
		DIV_SEL_CODE,
		DIV_SEL_AVG
	} div_sel_t;

	typedef struct packed {
		logic     div_start;
		div_sel_t div_sel;
		logic     div_step;
		logic     acc_load;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic reached;
		logic out_free;
	} status_t;

endpackage

// ===== hw/rtl/bga_ctrl.sv =====
// bga_ctrl: sequencing state machine of the battery gauge averaging block
// drives the datapath through bga_pkg::cmd_t and watches bga_pkg::status_t
// depends on bga_pkg
module bga_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bga_pkg::status_t  status,
	output bga_pkg::cmd_t     cmd
);

	bga_pkg::st_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bga_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			bga_pkg::ST_IDLE: begin
				if (in_valid) state_next = bga_pkg::ST_CONV;
			end
			bga_pkg::ST_CONV: begin
				if (status.div_done) state_next = bga_pkg::ST_ACC;
			end
			bga_pkg::ST_ACC: begin
				state_next = bga_pkg::ST_CHECK;
			end
			bga_pkg::ST_CHECK: begin
				state_next = status.reached ? bga_pkg::ST_AVG : bga_pkg::ST_IDLE;
			end
			bga_pkg::ST_AVG: begin
				if (status.div_done) state_next = bga_pkg::ST_EMIT;
			end
			bga_pkg::ST_EMIT: begin
				if (status.out_free) state_next = bga_pkg::ST_IDLE;
			end
			default: state_next = bga_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			bga_pkg::ST_IDLE: begin
				in_stall      = 1'b0;
				cmd.div_start = in_valid;
				cmd.div_sel   = bga_pkg::DIV_SEL_CODE;
			end
			bga_pkg::ST_CONV: begin
				cmd.div_step = 1'b1;
			end
			bga_pkg::ST_ACC: begin
				cmd.acc_load = 1'b1;
			end
			bga_pkg::ST_CHECK: begin
				cmd.div_start = status.reached;
				cmd.div_sel   = bga_pkg::DIV_SEL_AVG;
			end
			bga_pkg::ST_AVG: begin
				cmd.div_step = 1'b1;
			end
			bga_pkg::ST_EMIT: begin
				cmd.out_load = status.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== hw/rtl/bga_datapath.sv =====
// bga_datapath: configuration registers, shared restoring divider, accumulator,
// percentage mapping and output register of the battery gauge averaging block
// depends on bga_pkg
module bga_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [bga_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [bga_pkg::CfgW-1:0]         cfg_data,
	input  logic [bga_pkg::CodeW-1:0]        adc_code,
	input  bga_pkg::cmd_t                    cmd,
	output bga_pkg::status_t                 status,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [bga_pkg::MvW-1:0]          supply_millivolts,
	output logic [bga_pkg::PctW-1:0]         charge_percent
);

	localparam int SumW   = bga_pkg::SumW;
	localparam int CodeW  = bga_pkg::CodeW;
	localparam int CountW = bga_pkg::CountW;
	localparam int MvW    = bga_pkg::MvW;
	localparam int PctW   = bga_pkg::PctW;

	logic [CountW-1:0]        sample_count_q;
	logic [bga_pkg::NumW-1:0] ref_numer_q;

	logic [SumW-1:0]             quo_q;
	logic [CodeW-1:0]            rem_q;
	logic [CodeW-1:0]            dsr_q;
	logic [bga_pkg::DivCntW-1:0] cnt_q;
	logic [CodeW:0]              trial;
	logic                        trial_ge;

	logic [SumW-1:0]   sum_q;
	logic [CountW-1:0] count_q;
	logic [CountW-1:0] target;
	logic [MvW-1:0]    conv_mv;
	logic [MvW-1:0]    avg_mv;
	logic [PctW-1:0]   pct;
	logic              out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= bga_pkg::SampleCountReset;
			ref_numer_q    <= bga_pkg::RefNumerReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bga_pkg::CFG_SAMPLE_COUNT: sample_count_q <= cfg_data[CountW-1:0];
				bga_pkg::CFG_REF_NUMER:    ref_numer_q    <= cfg_data[bga_pkg::NumW-1:0];
				default: ;
			endcase
		end
	end

	// restoring divider, one quotient bit per cycle
	assign trial    = {rem_q, quo_q[SumW-1]};
	assign trial_ge = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= bga_pkg::DivCntW'(bga_pkg::DivSteps);
		end else if (cmd.div_step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			if (cmd.div_sel == bga_pkg::DIV_SEL_CODE) begin
				quo_q <= SumW'(ref_numer_q);
				dsr_q <= adc_code;
			end else begin
				quo_q <= sum_q;
				dsr_q <= CodeW'(count_q);
			end
		end else if (cmd.div_step && cnt_q != '0) begin
			rem_q <= trial_ge ? CodeW'(trial - {1'b0, dsr_q}) : trial[CodeW-1:0];
			quo_q <= {quo_q[SumW-2:0], trial_ge};
		end
	end

	// last step happens in the cycle that reports done
	assign status.div_done = (cnt_q == bga_pkg::DivCntW'(1));

	// zero code or oversize quotient saturate
	assign conv_mv = (dsr_q == '0 || quo_q[SumW-1:MvW] != '0) ? bga_pkg::MvSat : quo_q[MvW-1:0];
	assign avg_mv  = (quo_q[SumW-1:MvW] != '0) ? bga_pkg::MvSat : quo_q[MvW-1:0];

	assign target = (sample_count_q == '0) ? CountW'(1) : sample_count_q;
	assign status.reached = (count_q != '0) && (count_q >= target);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (cmd.acc_load) begin
			sum_q   <= sum_q + SumW'(conv_mv);
			count_q <= count_q + 1'b1;
		end else if (cmd.out_load) begin
			sum_q   <= '0;
			count_q <= '0;
		end
	end

	// piecewise-linear mapping; /10 and /20 by reciprocal multiply, /16 by shift
	always_comb begin
		logic [8:0]  diff;
		logic [16:0] prod;
		diff = '0;
		prod = '0;
		pct  = '0;
		if (avg_mv >= bga_pkg::MvFull) begin
			pct = bga_pkg::PctFull;
		end else if (avg_mv <= bga_pkg::MvEmpty) begin
			pct = '0;
		end else if (avg_mv > bga_pkg::MvKnee3) begin
			diff = 9'(avg_mv - bga_pkg::MvKnee3);
			prod = 17'(diff) * 17'd205;
			pct  = bga_pkg::PctKnee3 + PctW'(prod[16:12]);
			if (pct > bga_pkg::PctFull) pct = bga_pkg::PctFull;
		end else if (avg_mv > bga_pkg::MvKnee2) begin
			diff = 9'(avg_mv - bga_pkg::MvKnee2);
			prod = 17'(diff) * 17'd205;
			pct  = bga_pkg::PctKnee2 + PctW'(prod[16:11]);
		end else if (avg_mv > bga_pkg::MvKnee1) begin
			diff = 9'(avg_mv - bga_pkg::MvKnee1);
			prod = 17'(diff) * 17'd205;
			pct  = bga_pkg::PctKnee1 + PctW'(prod[16:11]);
		end else begin
			diff = 9'(avg_mv - bga_pkg::MvEmpty);
			pct  = PctW'(diff[8:4]);
		end
	end

	// output register
	assign status.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			supply_millivolts <= avg_mv;
			charge_percent    <= pct;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/battery_gauge_averaging.sv =====
// battery_gauge_averaging: supply voltage gauge from bandgap converter readings
// top level joining the controller bga_ctrl and the datapath bga_datapath
// depends on bga_pkg
//
// usage
// readings of the internal reference enter on in_valid/in_stall with adc_code; a request is
// taken at a clock edge with in_valid high and in_stall low. each reading becomes supply
// millivolts through a 24-step restoring divider (one quotient bit per cycle), is added to a
// running sum, and after sample_count readings one result leaves on out_valid/out_stall with
// supply_millivolts and charge_percent. a zero sample count acts as one.
// a reading that completes no average passes through conversion, accumulation and the check;
// the one that completes an average then also has the same divider compute sum / count.
// the divider is shared by both divisions; no new reading is taken until the block is idle.
// the result sits in an output register, so a new reading is taken while it waits; if the
// receiver still stalls when the next average is ready, the block holds in_stall high.
// configuration is written on cfg_valid/cfg_ready (cfg_ready is always high) with cfg_index
// 0 for sample_count and 1 for reference_numerator; the user must write it only while the
// block is idle, which the block itself does not enforce. reset clears the sum, the count and
// the output valid, and loads sample_count 10 and reference_numerator 1125300.
module battery_gauge_averaging (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bga_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bga_pkg::CfgW-1:0]     cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bga_pkg::CodeW-1:0]    adc_code,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [bga_pkg::MvW-1:0]      supply_millivolts,
	output logic [bga_pkg::PctW-1:0]     charge_percent
);

	bga_pkg::cmd_t    cmd;
	bga_pkg::status_t status;

	assign cfg_ready = 1'b1;

	bga_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	bga_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.adc_code          (adc_code),
		.cmd               (cmd),
		.status            (status),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.supply_millivolts (supply_millivolts),
		.charge_percent    (charge_percent)
	);

endmodule
